// ----- hw/rtl/ring_queue_with_search_remove_core_macros.svh -----
// Assertion macros for the ring queue block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RING_QUEUE_WITH_SEARCH_REMOVE_CORE_MACROS_SVH
`define RING_QUEUE_WITH_SEARCH_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rq_pkg.sv -----
// Shared types and constants for the ring queue block.
// Used by rq_cell and ring_queue_with_search_remove_core; no dependencies.
package rq_pkg;

    localparam int DEPTH  = 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int WORD_W = 16;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_FIND   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // input beat
    typedef struct packed {
        t_mode             mode;
        logic [WORD_W-1:0] value;
    } t_in;

    // result beat
    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] data;
        logic [SLOT_W-1:0] position;
        logic [CNT_W-1:0]  occupancy;
    } t_out;

    // per-cell control from the sequencer
    typedef struct packed {
        logic wr;        // store broadcast word
        logic shift;     // take neighbor's word (gap closing)
        logic tok_load;  // load search token
        logic tok_head;  // token value on load (this cell is the head)
        logic tok_run;   // take token from previous cell
    } t_cell_ctl;

endpackage

// ----- hw/rtl/rq_cell.sv -----
// One queue slot: holds a word, compares it with the search key and passes
// the search token along the ring. Depends on rq_pkg.
module rq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rq_pkg::t_cell_ctl         i_ctl,
    input  logic [rq_pkg::WORD_W-1:0] i_wdata,
    input  logic [rq_pkg::WORD_W-1:0] i_nb_word,
    input  logic [rq_pkg::WORD_W-1:0] i_key,
    input  logic                      i_tok,
    output logic [rq_pkg::WORD_W-1:0] o_word,
    output logic                      o_tok,
    output logic                      o_hit
);
    import rq_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic              r_tok;

    // stored word: append write or shift from the next slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_word <= i_wdata;
        end else if (i_ctl.shift) begin
            r_word <= i_nb_word;
        end
    end

    // search token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.tok_load) begin
            r_tok <= i_ctl.tok_head;
        end else if (i_ctl.tok_run) begin
            r_tok <= i_tok;
        end
    end

    assign o_word = r_word;
    assign o_tok  = r_tok;
    assign o_hit  = r_tok && (r_word == i_key);

endmodule

// ----- hw/rtl/ring_queue_with_search_remove_core.sv -----
// Ring queue of 16-bit words with append, pop, remove-by-value and find.
// Built from a ring of rq_cell slots; depends on rq_pkg and the macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one operation
//   per beat; output channel (o_out_valid / i_out_stall / o_out_data) returns
//   exactly one result beat per operation, in order.
//   i_cfg_we / i_cfg_wdata write the capacity register (0 acts as 1, above
//   16 acts as 16) and empty the queue; write it only while the block is idle.
// Sequence:
//   Append and pop: the accepting idle state is followed by the done state,
//   which loads the result register; no new beat is taken until the block
//   is back in the idle state. Find runs the search state until the match,
//   remove adds the shift state after it; without a match both search every
//   held entry from the head. The search token walks one slot per cycle
//   around the cell ring.
// Reset (synchronous, active low): queue empty, capacity 16, no result.
// A stalled result stays in the output register; the block finishes at most
// one more operation and then holds o_in_stall high until the result leaves.
`include "ring_queue_with_search_remove_core_macros.svh"

module ring_queue_with_search_remove_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  rq_pkg::t_in              i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output rq_pkg::t_out             o_out_data,
    input  logic                     i_cfg_we,
    input  logic [rq_pkg::CNT_W-1:0] i_cfg_wdata
);
    import rq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] r_tail;
    logic              r_empty;
    logic [CNT_W-1:0]  r_cap;
    t_mode             r_mode;
    logic [WORD_W-1:0] r_value;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_found;
    t_status           r_pend_status;
    logic [WORD_W-1:0] r_pend_data;
    logic [SLOT_W-1:0] r_pend_pos;
    logic              r_out_valid;
    t_out              r_out;

    logic [CNT_W-1:0]  capv;
    logic [SLOT_W-1:0] capm1;
    logic [CNT_W-1:0]  occ;
    logic              in_acc;
    logic              full;
    logic [SLOT_W-1:0] app_slot;
    logic              out_free;
    logic              any_hit;
    logic [SLOT_W-1:0] hit_pos;
    logic [CNT_W-1:0]  span;

    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [DEPTH-1:0]  cell_tok;
    logic [DEPTH-1:0]  cell_hit;
    logic [DEPTH-1:0]  shift_en;
    t_cell_ctl         cell_ctl  [DEPTH];

    // next slot with wrap at the active capacity
    function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] s,
                                              input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] n;
        n = {1'b0, s} + CNT_W'(1);
        return (n >= cap) ? '0 : n[SLOT_W-1:0];
    endfunction

    // distance from a to b walking upward with wrap
    function automatic logic [CNT_W-1:0] ring_dist(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] d;
        if (b >= a) begin
            d = b - a;
        end else begin
            d = b + cap - a;
        end
        return d;
    endfunction

    // effective capacity
    always_comb begin
        if (r_cap == '0) begin
            capv = CNT_W'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            capv = CNT_W'(DEPTH);
        end else begin
            capv = r_cap;
        end
        capm1 = SLOT_W'(capv - CNT_W'(1));
    end

    // entries held
    always_comb begin
        if (r_empty) begin
            occ = '0;
        end else begin
            occ = ring_dist({1'b0, r_head}, {1'b0, r_tail}, capv) + CNT_W'(1);
        end
    end

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign full       = !r_empty && (r_head == nxt(r_tail, capv));
    assign app_slot   = r_empty ? '0 : nxt(r_tail, capv);
    assign out_free   = !r_out_valid || !i_out_stall;

    // match encode (only one token is live)
    always_comb begin
        any_hit = |cell_hit;
        hit_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (cell_hit[k]) begin
                hit_pos = hit_pos | SLOT_W'(k);
            end
        end
    end

    // gap closing range: slots from the match up to one before the tail
    always_comb begin
        span = ring_dist({1'b0, r_found}, {1'b0, r_tail}, capv);
        for (int k = 0; k < DEPTH; k++) begin
            shift_en[k] = (CNT_W'(k) < capv) &&
                          (ring_dist({1'b0, r_found}, CNT_W'(k), capv) < span);
        end
    end

    // per-cell control
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_ctl[k].wr       = in_acc && (i_in_data.mode == MODE_APPEND) && !full &&
                                   (app_slot == SLOT_W'(k));
            cell_ctl[k].shift    = (r_state == S_SHIFT) && shift_en[k];
            cell_ctl[k].tok_load = in_acc && ((i_in_data.mode == MODE_REMOVE) ||
                                              (i_in_data.mode == MODE_FIND));
            cell_ctl[k].tok_head = (r_head == SLOT_W'(k));
            cell_ctl[k].tok_run  = (r_state == S_SEARCH);
        end
    end

    // cell ring
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam int NK = (k + 1) % DEPTH;
        logic [WORD_W-1:0] nb_word;
        logic              tok_in;

        assign nb_word = (SLOT_W'(k) == capm1) ? cell_word[0] : cell_word[NK];
        if (k == 0) begin : g_first
            assign tok_in = cell_tok[capm1];
        end else begin : g_rest
            assign tok_in = cell_tok[k-1] && (CNT_W'(k) < capv);
        end

        rq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl[k]),
            .i_wdata   (i_in_data.value),
            .i_nb_word (nb_word),
            .i_key     (r_value),
            .i_tok     (tok_in),
            .o_word    (cell_word[k]),
            .o_tok     (cell_tok[k]),
            .o_hit     (cell_hit[k])
        );
    end

    // sequencer, pointers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_cap       <= CNT_W'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode        <= i_in_data.mode;
                        r_value       <= i_in_data.value;
                        r_cnt         <= occ;
                        r_pend_status <= ST_OK;
                        r_pend_data   <= '0;
                        r_pend_pos    <= '0;
                        r_state       <= S_DONE;
                        unique case (i_in_data.mode)
                            MODE_APPEND: begin
                                if (full) begin
                                    r_pend_status <= ST_FULL;
                                end else begin
                                    r_head     <= r_empty ? '0 : r_head;
                                    r_tail     <= app_slot;
                                    r_empty    <= 1'b0;
                                    r_pend_pos <= app_slot;
                                end
                            end
                            MODE_POP: begin
                                if (r_empty) begin
                                    r_pend_status <= ST_EMPTY;
                                end else begin
                                    r_pend_data <= cell_word[r_head];
                                    if (r_head == r_tail) begin
                                        r_head  <= '0;
                                        r_tail  <= '0;
                                        r_empty <= 1'b1;
                                    end else begin
                                        r_head <= nxt(r_head, capv);
                                    end
                                end
                            end
                            MODE_REMOVE, MODE_FIND: begin
                                if (r_empty) begin
                                    r_pend_status <= ST_NOT_FOUND;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else if (i_cfg_we) begin
                        r_cap   <= i_cfg_wdata;
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_empty <= 1'b1;
                    end
                end
                S_SEARCH: begin
                    if (any_hit) begin
                        if (r_mode == MODE_FIND) begin
                            r_pend_pos <= hit_pos;
                            r_state    <= S_DONE;
                        end else begin
                            r_found <= hit_pos;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_cnt == CNT_W'(1)) begin
                        r_pend_status <= ST_NOT_FOUND;
                        r_state       <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_SHIFT: begin
                    // cells move their words this cycle; fix up the tail
                    if (r_head == r_tail) begin
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_empty <= 1'b1;
                    end else begin
                        r_tail <= (r_tail == '0) ? capm1 : r_tail - SLOT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.status    <= r_pend_status;
                        r_out.data      <= r_pend_data;
                        r_out.position  <= r_pend_pos;
                        r_out.occupancy <= occ;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `RQ_ASSERT_IMPL(a_tok_single, i_clk, i_rst_n, r_state == S_SEARCH,
                    $onehot(cell_tok), "search token lost or duplicated")
    `RQ_ASSERT_IMPL(a_empty_ptrs, i_clk, i_rst_n, r_empty,
                    (r_head == '0) && (r_tail == '0), "empty queue with stray pointers")
    `RQ_ASSERT_IMPL(a_occ_range, i_clk, i_rst_n, 1'b1,
                    occ <= capv, "occupancy above capacity")
    `RQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc,
                    r_state != S_IDLE, "accepted beat did not start work")
    `RQ_ASSERT_IMPL(a_cnt_live, i_clk, i_rst_n, r_state == S_SEARCH,
                    r_cnt != '0, "search running with no entries left")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for ring_queue_with_search_remove_core.
// Drives append/pop/remove/find beats against a cycle-free queue predictor;
// depends only on rq_pkg and the core under test.
module tb;
    import rq_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = 25;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 200;
    localparam int POOL_SIZE    = 6;

    // kinds of random bursts
    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_SEARCH,
        BURST_NOISE
    } t_burst;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in              i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;

    ring_queue_with_search_remove_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // pending operations and predicted result beats
    t_in  pending_ops[$];
    t_out expected_results[$];

    int errors       = 0;
    int cycle_count  = 0;
    int cap_writes   = 0;
    int ops_by_mode[4];
    int results_by_status[4];
    bit quiet_run    = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_cycles  = 0;

    logic [WORD_W-1:0] word_pool[POOL_SIZE];

    // queue mirror
    logic [WORD_W-1:0] mirror_mem[DEPTH];
    int               mirror_head  = 0;
    int               mirror_tail  = 0;
    bit               mirror_empty = 1'b1;
    logic [CNT_W-1:0] mirror_cap   = CNT_W'(16);

    // capacity as the block sees it: 0 acts as 1, above DEPTH acts as DEPTH
    function automatic int wrap_cap();
        if (mirror_cap == 0) return 1;
        if (int'(mirror_cap) > DEPTH) return DEPTH;
        return int'(mirror_cap);
    endfunction

    function automatic int next_slot_of(int s, int c);
        return (s + 1 >= c) ? 0 : s + 1;
    endfunction

    function automatic int held_count(int c);
        if (mirror_empty) return 0;
        if (mirror_tail >= mirror_head) return mirror_tail - mirror_head + 1;
        return mirror_tail + c - mirror_head + 1;
    endfunction

    // first match walking from the head over every held entry
    function automatic bit locate_word(logic [WORD_W-1:0] w, int c, output int slot);
        int n;
        int s;
        n = held_count(c);
        s = mirror_head;
        slot = 0;
        for (int i = 0; i < n; i++) begin
            if (mirror_mem[s] == w) begin
                slot = s;
                return 1'b1;
            end
            s = next_slot_of(s, c);
        end
        return 1'b0;
    endfunction

    // apply one operation to the mirror and return its result beat
    function automatic t_out apply_op(t_in op);
        t_out r;
        int   c;
        int   slot;
        int   nxt;
        c = wrap_cap();
        r = '0;
        r.status = ST_OK;
        case (op.mode)
            MODE_APPEND: begin
                if (!mirror_empty && mirror_head == next_slot_of(mirror_tail, c)) begin
                    r.status = ST_FULL;
                end else begin
                    if (mirror_empty) begin
                        mirror_head  = 0;
                        mirror_tail  = 0;
                        mirror_empty = 1'b0;
                    end else begin
                        mirror_tail = next_slot_of(mirror_tail, c);
                    end
                    mirror_mem[mirror_tail] = op.value;
                    r.position = SLOT_W'(mirror_tail);
                end
            end
            MODE_POP: begin
                if (mirror_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = mirror_mem[mirror_head];
                    if (mirror_head == mirror_tail) begin
                        mirror_head  = 0;
                        mirror_tail  = 0;
                        mirror_empty = 1'b1;
                    end else begin
                        mirror_head = next_slot_of(mirror_head, c);
                    end
                end
            end
            MODE_REMOVE: begin
                if (!locate_word(op.value, c, slot)) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    // close the gap toward the head
                    while (slot != mirror_tail) begin
                        nxt = next_slot_of(slot, c);
                        mirror_mem[slot] = mirror_mem[nxt];
                        slot = nxt;
                    end
                    if (mirror_head == mirror_tail) begin
                        mirror_head  = 0;
                        mirror_tail  = 0;
                        mirror_empty = 1'b1;
                    end else begin
                        mirror_tail = (mirror_tail == 0) ? c - 1 : mirror_tail - 1;
                    end
                end
            end
            default: begin
                if (!locate_word(op.value, c, slot)) r.status = ST_NOT_FOUND;
                else r.position = SLOT_W'(slot);
            end
        endcase
        r.occupancy = CNT_W'(held_count(c));
        return r;
    endfunction

    // sender: offers the front pending beat, holds it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_op(i_in_data));
                ops_by_mode[i_in_data.mode]++;
                void'(pending_ops.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                    send_gap   <= $urandom_range(0, 13);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_ops[0];
                end
            end
        end
    end

    // receiver stall: one long hold-off on request, else random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap    <= 0;
            hold_cycles <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (hold_request && !hold_done) begin
            hold_done   <= 1'b1;
            hold_cycles <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap    <= recv_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            recv_gap    <= $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, actual status %0d data %0d",
                         $time, o_out_data.status, o_out_data.data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("status",    32'(want.status),    32'(o_out_data.status));
                check_field("data",      32'(want.data),      32'(o_out_data.data));
                check_field("position",  32'(want.position),  32'(o_out_data.position));
                check_field("occupancy", 32'(want.occupancy), 32'(o_out_data.occupancy));
                results_by_status[want.status]++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats pending, %0d results outstanding",
                     $time, pending_ops.size(), expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_op(t_mode m, logic [WORD_W-1:0] v);
        t_in op;
        op.mode  = m;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    // wait until everything sent has come back, then let the block settle
    task automatic drain(int extra);
        while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // capacity write while idle; also empties the mirror
    task automatic set_capacity(logic [CNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        mirror_cap   = v;
        mirror_head  = 0;
        mirror_tail  = 0;
        mirror_empty = 1'b1;
        cap_writes++;
        repeat (2) @(posedge i_clk);
    endtask

    // bursts of well-formed traffic over a small word pool, plus noise
    task automatic queue_random_ops(int count);
        t_burst            kind;
        int                len;
        int                pick;
        t_mode             m;
        logic [WORD_W-1:0] v;
        for (int i = 0; i < POOL_SIZE; i++) word_pool[i] = WORD_W'($urandom_range(0, 65535));
        while (count > 0) begin
            kind = t_burst'($urandom_range(0, 3));
            len  = $urandom_range(4, 24);
            for (int i = 0; i < len && count > 0; i++) begin
                pick = $urandom_range(0, 99);
                case (kind)
                    BURST_FILL:
                        m = (pick < 70) ? MODE_APPEND : (pick < 85) ? MODE_FIND :
                            (pick < 95) ? MODE_REMOVE : MODE_POP;
                    BURST_DRAIN:
                        m = (pick < 60) ? MODE_POP : (pick < 80) ? MODE_REMOVE :
                            (pick < 95) ? MODE_FIND : MODE_APPEND;
                    BURST_SEARCH:
                        m = (pick < 30) ? MODE_APPEND : (pick < 60) ? MODE_REMOVE :
                            (pick < 90) ? MODE_FIND : MODE_POP;
                    default:
                        m = t_mode'($urandom_range(0, 3));
                endcase
                if (kind == BURST_NOISE || $urandom_range(0, 4) == 0)
                    v = WORD_W'($urandom_range(0, 65535));
                else
                    v = word_pool[$urandom_range(0, POOL_SIZE - 1)];
                add_op(m, v);
                count--;
            end
        end
    endtask

    initial begin
        logic [CNT_W-1:0] phase_caps[10];
        phase_caps = '{CNT_W'(1), CNT_W'(0), CNT_W'(2), CNT_W'(3), CNT_W'(16),
                       CNT_W'(31), CNT_W'($urandom_range(1, 16)),
                       CNT_W'($urandom_range(0, 31)), CNT_W'(4), CNT_W'(16)};
        foreach (ops_by_mode[i]) ops_by_mode[i] = 0;
        foreach (results_by_status[i]) results_by_status[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed, reset capacity: empty cases, word extremes, duplicates
        add_op(MODE_POP,    16'h0000);
        add_op(MODE_REMOVE, 16'h0000);
        add_op(MODE_FIND,   16'hFFFF);
        add_op(MODE_APPEND, 16'h0000);
        add_op(MODE_APPEND, 16'hFFFF);
        add_op(MODE_APPEND, 16'h0000);
        add_op(MODE_FIND,   16'h0000);
        add_op(MODE_FIND,   16'h5A5A);
        add_op(MODE_REMOVE, 16'hFFFF);
        add_op(MODE_FIND,   16'h0000);
        add_op(MODE_POP,    16'h0000);
        add_op(MODE_POP,    16'h0000);
        add_op(MODE_POP,    16'h0000);
        drain(SETTLE_WAIT);

        // directed, capacity 4: full, full-queue search, wrap, remove across wrap
        set_capacity(CNT_W'(4));
        add_op(MODE_APPEND, 16'h1111);
        add_op(MODE_APPEND, 16'h2222);
        add_op(MODE_APPEND, 16'h3333);
        add_op(MODE_APPEND, 16'h4444);
        add_op(MODE_APPEND, 16'h5555);
        add_op(MODE_FIND,   16'h4444);
        add_op(MODE_POP,    16'h0000);
        add_op(MODE_APPEND, 16'h5555);
        add_op(MODE_REMOVE, 16'h3333);
        add_op(MODE_FIND,   16'h5555);
        add_op(MODE_REMOVE, 16'h5555);
        drain(SETTLE_WAIT);

        // random phases over a spread of capacities
        foreach (phase_caps[p]) begin
            set_capacity(phase_caps[p]);
            quiet_run = (p == 9);
            if (p == 2) begin
                // sender stops mid-phase until everything has returned
                queue_random_ops(PHASE_ITEMS / 2);
                drain(0);
                queue_random_ops(PHASE_ITEMS / 2);
            end else begin
                queue_random_ops(PHASE_ITEMS);
                // long receiver hold-off while beats keep coming
                if (p == 4) hold_request = 1'b1;
            end
            drain(SETTLE_WAIT);
        end

        drain(SETTLE_WAIT);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("Covered %0d appends, %0d pops, %0d removes, %0d finds over %0d capacity writes",
                 ops_by_mode[MODE_APPEND], ops_by_mode[MODE_POP],
                 ops_by_mode[MODE_REMOVE], ops_by_mode[MODE_FIND], cap_writes);
        $display("Results: %0d ok, %0d full, %0d empty, %0d not found; %0d errors",
                 results_by_status[ST_OK], results_by_status[ST_FULL],
                 results_by_status[ST_EMPTY], results_by_status[ST_NOT_FOUND], errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
